[src/mcfp_pkg.sv]
// shared types and constants for the midi and command frame parser
// no dependencies; imported by every module of the block
package mcfp_pkg;

	// register indexes of the configuration port
	localparam logic [1:0] REG_HEADER_FIRST  = 2'd0;
	localparam logic [1:0] REG_HEADER_SECOND = 2'd1;
	localparam logic [1:0] REG_MAX_LENGTH    = 2'd2;
	localparam logic [1:0] REG_HANDSHAKE_CMD = 2'd3;

	// reset value of the length limit
	localparam logic [7:0] MAX_LENGTH_RESET = 8'd16;

	// midi status high nibbles (low nibble masked)
	localparam logic [7:0] ST_NOTE_OFF    = 8'h80;
	localparam logic [7:0] ST_NOTE_ON     = 8'h90;
	localparam logic [7:0] ST_CONTROL     = 8'hB0;
	localparam logic [7:0] ST_PROGRAM     = 8'hC0;
	localparam logic [7:0] ST_PITCH_BEND  = 8'hE0;
	localparam logic [7:0] HI_NIBBLE_MASK = 8'hF0;

	// handshake data values
	localparam logic [7:0] HS_ACK     = 8'h01;
	localparam logic [7:0] HS_REQUEST = 8'h00;

	// packet kinds
	localparam logic KIND_MIDI    = 1'b0;
	localparam logic KIND_COMMAND = 1'b1;

	// midi body lengths
	localparam logic [7:0] MIDI_LEN_SHORT = 8'd2;
	localparam logic [7:0] MIDI_LEN_LONG  = 8'd3;

	// output tdata width: four bytes and two flags, padded to whole bytes
	localparam int RES_BITS   = 34;
	localparam int TDATA_BITS = ((RES_BITS + 7) / 8) * 8;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEAD2  = 3'd1,
		PH_LENGTH = 3'd2,
		PH_BODY   = 3'd3,
		PH_MIDI   = 3'd4
	} phase_t;

	typedef struct packed {
		logic [7:0] header_first;
		logic [7:0] header_second;
		logic [7:0] max_command_length;
		logic [7:0] handshake_command;
	} cfg_t;

	typedef struct packed {
		logic       link_connected;
		logic       handshake_reply;
		logic [7:0] packet_length;
		logic [7:0] byte_two;
		logic [7:0] byte_one;
		logic [7:0] byte_zero;
		logic       packet_kind;
	} result_t;

endpackage

[src/mcfp_cfg_regs.sv]
// configuration register bank of the parser
// depends on mcfp_pkg for register indexes and the cfg_t struct
module mcfp_cfg_regs import mcfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first       <= '0;
			cfg_q.header_second      <= '0;
			cfg_q.max_command_length <= MAX_LENGTH_RESET;
			cfg_q.handshake_command  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_HEADER_FIRST:  cfg_q.header_first       <= cfg_data;
				REG_HEADER_SECOND: cfg_q.header_second      <= cfg_data;
				REG_MAX_LENGTH:    cfg_q.max_command_length <= cfg_data;
				REG_HANDSHAKE_CMD: cfg_q.handshake_command  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

[src/mcfp_decoder.sv]
// byte decoder: input register, parser state and the per-byte update
// depends on mcfp_pkg for phase codes, constants and the cfg_t / result_t structs
module mcfp_decoder import mcfp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       res_valid,
	input  logic       res_ready,
	output result_t    res
);

	logic       byte_valid_s1;
	logic [7:0] byte_s1;

	phase_t     phase_q, phase_d;
	logic [7:0] count_q, count_d;
	logic [7:0] exp_len_q, exp_len_d;
	logic [7:0] kept_q [3];
	logic [7:0] kept_d [3];
	logic       connected_q, connected_d;

	logic       advance;
	logic [7:0] hi;
	logic [7:0] count_inc;
	logic [7:0] k0, k1, k2;
	logic       done;
	logic       reply;

	// the held byte moves on when the result side has room
	assign advance  = byte_valid_s1 && res_ready;
	assign in_ready = !byte_valid_s1 || res_ready;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			byte_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// kept bytes after storing the current byte
	assign hi        = byte_s1 & HI_NIBBLE_MASK;
	assign count_inc = count_q + 8'd1;
	assign k0        = (count_q == 8'd0) ? byte_s1 : kept_q[0];
	assign k1        = (count_q == 8'd1) ? byte_s1 : kept_q[1];
	assign k2        = (count_q == 8'd2) ? byte_s1 : kept_q[2];

	// next state and result
	always_comb begin
		phase_d     = phase_q;
		count_d     = count_q;
		exp_len_d   = exp_len_q;
		kept_d      = kept_q;
		connected_d = connected_q;
		done        = 1'b0;
		reply       = 1'b0;

		res.packet_kind     = KIND_MIDI;
		res.byte_zero       = k0;
		res.byte_one        = k1;
		res.byte_two        = k2;
		res.packet_length   = exp_len_q;
		res.handshake_reply = 1'b0;
		res.link_connected  = connected_q;

		case (phase_q)
			PH_IDLE: begin
				if (hi inside {ST_NOTE_OFF, ST_NOTE_ON, ST_CONTROL, ST_PROGRAM,
						ST_PITCH_BEND}) begin
					exp_len_d = (hi == ST_PROGRAM) ? MIDI_LEN_SHORT : MIDI_LEN_LONG;
					kept_d[0] = byte_s1;
					count_d   = 8'd1;
					phase_d   = PH_MIDI;
				end else if (byte_s1 == cfg.header_first) begin
					phase_d = PH_HEAD2;
				end
			end
			PH_HEAD2: begin
				phase_d = (byte_s1 == cfg.header_second) ? PH_LENGTH : PH_IDLE;
			end
			PH_LENGTH: begin
				if (byte_s1 <= cfg.max_command_length) begin
					exp_len_d = byte_s1;
					phase_d   = PH_BODY;
				end else begin
					phase_d = PH_IDLE;
				end
			end
			PH_BODY: begin
				kept_d[0] = k0;
				kept_d[1] = k1;
				kept_d[2] = k2;
				count_d   = count_inc;
				if (count_inc >= exp_len_q) begin
					done = 1'b1;
					if (k0 == cfg.handshake_command) begin
						if (k1 == HS_ACK) begin
							connected_d = 1'b1;
						end else if (k1 == HS_REQUEST) begin
							reply = 1'b1;
						end
					end
				end
				res.packet_kind     = KIND_COMMAND;
				res.handshake_reply = reply;
				res.link_connected  = connected_d;
			end
			PH_MIDI: begin
				kept_d[0] = k0;
				kept_d[1] = k1;
				kept_d[2] = k2;
				count_d   = count_inc;
				done      = (count_inc >= exp_len_q);
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase

		// back to idle clears everything but the connected flag
		if (done || phase_d == PH_IDLE) begin
			phase_d   = PH_IDLE;
			count_d   = '0;
			exp_len_d = '0;
			kept_d[0] = '0;
			kept_d[1] = '0;
			kept_d[2] = '0;
		end
	end

	assign res_valid = byte_valid_s1 && done;

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			count_q     <= '0;
			exp_len_q   <= '0;
			kept_q[0]   <= '0;
			kept_q[1]   <= '0;
			kept_q[2]   <= '0;
			connected_q <= 1'b0;
		end else if (advance) begin
			phase_q     <= phase_d;
			count_q     <= count_d;
			exp_len_q   <= exp_len_d;
			kept_q      <= kept_d;
			connected_q <= connected_d;
		end
	end

`ifndef ASSERT_OFF
	// idle always carries cleared counters
	a_idle_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (count_q == 8'd0 && exp_len_q == 8'd0))
		else $error("idle phase with stale byte count or length");

	// a completed packet leaves the parser idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> (phase_q == PH_IDLE))
		else $error("parser not idle after a completed packet");

	// the connected flag is never cleared by parsing
	a_conn_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(connected_q))
		else $error("connected flag dropped");

	// a midi result never carries a handshake reply
	a_midi_reply: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.packet_kind == KIND_MIDI) |-> !res.handshake_reply)
		else $error("handshake reply on a midi result");
`endif

endmodule

[src/mcfp_out_reg.sv]
// result register on the master side, takes a new result while one is being drained
// depends on mcfp_pkg for the result_t struct and output widths
module mcfp_out_reg import mcfp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  res_valid,
	output logic                  res_ready,
	input  result_t               res,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [TDATA_BITS-1:0] m_tdata,
	output logic                  m_tuser
);

	logic    valid_q;
	result_t res_q;

	assign res_ready = !valid_q || m_tready;

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

	// pack the master-side request
	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.packet_kind;
	assign m_tdata  = {{(TDATA_BITS - RES_BITS){1'b0}},
		res_q.link_connected, res_q.handshake_reply, res_q.packet_length,
		res_q.byte_two, res_q.byte_one, res_q.byte_zero};

endmodule

[src/midi_and_command_frame_parser.sv]
// top level of the midi channel message and command frame parser
// depends on mcfp_pkg, mcfp_cfg_regs, mcfp_decoder and mcfp_out_reg
// Takes one received serial byte per request on the slave side and recognises
// midi channel messages (status 8x, 9x, Bx or Ex plus two data bytes, Cx plus
// one, no running status) and command frames (two header bytes, a length byte
// not above max_command_length, then that many body bytes, at least one). A
// byte that does not fit quietly returns the parser to idle. Each completed
// packet gives one master-side request with its first three bytes (missing
// ones zero). A byte is accepted every clock cycle unless the master side
// stalls; the completing byte passes the input register and then the result
// register; the per-byte state update is the only loop. Configuration writes
// are always taken and must only be made while no packet is in progress.
module midi_and_command_frame_parser import mcfp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [7:0]            cfg_data,
	// slave side
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [7:0]            s_tdata,  // rx_byte
	// master side
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// byte_zero, byte_one, byte_two, packet_length, handshake_reply,
	// link_connected, zero padding
	output logic [TDATA_BITS-1:0] m_tdata,
	output logic                  m_tuser   // packet_kind
);

	cfg_t    cfg;
	result_t res;
	logic    res_valid;
	logic    res_ready;

	// configuration registers
	mcfp_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// byte decoder
	mcfp_decoder u_decoder (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_byte   (s_tdata),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// result register
	mcfp_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
